>>> hdl/fmv_pkg.sv
`timescale 1ns / 1ps

package fmv_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_DEPTH_INDEX     = 3'd0;
   localparam logic [2:0] CSR_PHASE_INCREMENT = 3'd1;
   localparam logic [2:0] CSR_MEAN_OFFSET     = 3'd2;
   localparam logic [2:0] CSR_LOOKAHEAD       = 3'd3;
   localparam logic [2:0] CSR_PAN             = 3'd4;
   localparam logic [2:0] CSR_STEREO_OUT      = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // one in Q1.16
   localparam logic [16:0] UNITY = 17'h10000;

   // operand selection for the shared multiplier
   typedef enum logic [2:0] {
      MUL_INTERP = 3'd0,
      MUL_DEPTH  = 3'd1,
      MUL_OLD    = 3'd2,
      MUL_NEW    = 3'd3,
      MUL_GAIN   = 3'd4,
      MUL_PANL   = 3'd5,
      MUL_PANR   = 3'd6
   } mul_sel_type;

   typedef struct packed {
      logic        clear_step;
      logic        latch;
      logic        tbl_write;
      logic        ring_write;
      logic        cap_t0;
      logic        cap_t1;
      logic        phase_adv;
      logic        offset_upd;
      logic        addr_calc;
      logic        ring_rd1;
      logic        cap_s0;
      logic        cap_s1;
      logic        acc_load;
      logic        acc_add;
      logic        cap_a;
      logic        cap_left;
      logic        cap_right;
      logic        out_load;
      mul_sel_type mul_sel;
   } fmv_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic stereo;
      logic out_free;
   } fmv_status_type;

endpackage

>>> hdl/fmv_ram.sv
`timescale 1ns / 1ps

module fmv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fmv_ctrl.sv
`timescale 1ns / 1ps

module fmv_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,
   input  fmv_pkg::fmv_status_type status,
   output fmv_pkg::fmv_cmd_type    cmd
);

   typedef enum logic [20:0] {
      S_CLEAR = 21'd1 << 0,
      S_IDLE  = 21'd1 << 1,
      S_LOAD  = 21'd1 << 2,
      S_RING  = 21'd1 << 3,
      S_T0    = 21'd1 << 4,
      S_T1    = 21'd1 << 5,
      S_MI    = 21'd1 << 6,
      S_MD    = 21'd1 << 7,
      S_OFS   = 21'd1 << 8,
      S_ADR   = 21'd1 << 9,
      S_R0    = 21'd1 << 10,
      S_R1    = 21'd1 << 11,
      S_MO    = 21'd1 << 12,
      S_MN    = 21'd1 << 13,
      S_VS    = 21'd1 << 14,
      S_MG    = 21'd1 << 15,
      S_CA    = 21'd1 << 16,
      S_PL    = 21'd1 << 17,
      S_PR    = 21'd1 << 18,
      S_RT    = 21'd1 << 19,
      S_OUT   = 21'd1 << 20
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = fmv_pkg::MUL_INTERP;
      state_in    = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = req_tuser ? S_RING : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.tbl_write = 1'b1;
            state_in      = S_IDLE;
         end
         S_RING: begin
            cmd.ring_write = 1'b1;
            state_in       = S_T0;
         end
         S_T0: begin
            cmd.cap_t0 = 1'b1;
            state_in   = S_T1;
         end
         S_T1: begin
            cmd.cap_t1 = 1'b1;
            state_in   = S_MI;
         end
         S_MI: begin
            cmd.mul_sel = fmv_pkg::MUL_INTERP;
            state_in    = S_MD;
         end
         S_MD: begin
            cmd.mul_sel   = fmv_pkg::MUL_DEPTH;
            cmd.phase_adv = 1'b1;
            state_in      = S_OFS;
         end
         S_OFS: begin
            cmd.offset_upd = 1'b1;
            state_in       = S_ADR;
         end
         S_ADR: begin
            cmd.addr_calc = 1'b1;
            state_in      = S_R0;
         end
         S_R0: begin
            state_in = S_R1;
         end
         S_R1: begin
            cmd.ring_rd1 = 1'b1;
            cmd.cap_s0   = 1'b1;
            state_in     = S_MO;
         end
         S_MO: begin
            cmd.cap_s1  = 1'b1;
            cmd.mul_sel = fmv_pkg::MUL_OLD;
            state_in    = S_MN;
         end
         S_MN: begin
            cmd.mul_sel  = fmv_pkg::MUL_NEW;
            cmd.acc_load = 1'b1;
            state_in     = S_VS;
         end
         S_VS: begin
            cmd.acc_add = 1'b1;
            state_in    = S_MG;
         end
         S_MG: begin
            cmd.mul_sel = fmv_pkg::MUL_GAIN;
            state_in    = S_CA;
         end
         S_CA: begin
            cmd.cap_a = 1'b1;
            state_in  = status.stereo ? S_PL : S_OUT;
         end
         S_PL: begin
            cmd.mul_sel = fmv_pkg::MUL_PANL;
            state_in    = S_PR;
         end
         S_PR: begin
            cmd.mul_sel  = fmv_pkg::MUL_PANR;
            cmd.cap_left = 1'b1;
            state_in     = S_RT;
         end
         S_RT: begin
            cmd.cap_right = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/fmv_datapath.sv
`timescale 1ns / 1ps

module fmv_datapath #(
   parameter int DELAY_DEPTH = 1024,
   parameter int TABLE_SIZE  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [((42 + SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   input  logic                                       csr_we,
   input  logic [fmv_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [fmv_pkg::CSR_DATA_W-1:0]             csr_wdata,
   input  fmv_pkg::fmv_cmd_type                       cmd,
   output fmv_pkg::fmv_status_type                    status,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   output logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0]  rsp_tdata
);

   localparam int SB     = SAMPLE_BITS;
   localparam int OUT_W  = ((2 * SB + 7) / 8) * 8;
   localparam int DAW    = $clog2(DELAY_DEPTH);
   localparam int TAW    = $clog2(TABLE_SIZE);
   localparam int RO_W   = ((DAW > 10) ? DAW : 10) + 18;
   localparam int D_W    = 27;
   localparam int SUM_W  = ((RO_W > D_W) ? RO_W : D_W) + 1;
   localparam int MA_W   = SB + 20;
   localparam int MB_W   = 25;
   localparam int P_W    = MA_W + MB_W;
   localparam int V_W    = SB + 18;
   localparam int MOD_SH = 10 + TAW;
   localparam longint MOD_M = ((longint'(1) << MOD_SH) + TABLE_SIZE - 1) / TABLE_SIZE;
   localparam logic signed [P_W-1:0] SMAX = P_W'((longint'(1) << (SB - 1)) - 1);
   localparam logic signed [P_W-1:0] SMIN = P_W'(-(longint'(1) << (SB - 1)));

   // reduce a 10-bit index modulo the table size by reciprocal multiply
   function automatic logic [TAW-1:0] tbl_mod(input logic [9:0] x);
      logic [47:0] mp;
      logic [9:0]  q;
      logic [31:0] r;
      mp = 48'(x) * 48'(MOD_M);
      q  = 10'(mp >> MOD_SH);
      r  = 32'(x) - 32'(q) * 32'(TABLE_SIZE);
      if (r >= 32'(TABLE_SIZE)) r = r - 32'(TABLE_SIZE);
      return TAW'(r);
   endfunction

   function automatic logic signed [SB-1:0] sat(input logic signed [P_W-1:0] x);
      logic signed [P_W-1:0] y;
      y = x;
      if (x > SMAX) y = SMAX;
      if (x < SMIN) y = SMIN;
      return SB'(y);
   endfunction

   // configuration
   logic [23:0]        depth_ff;
   logic [31:0]        pinc_ff;
   logic signed [23:0] mean_ff;
   logic [9:0]         look_ff;
   logic [16:0]        pan_ff;
   logic               stereo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         pinc_ff   <= '0;
         mean_ff   <= '0;
         look_ff   <= '0;
         pan_ff    <= 17'd32768;
         stereo_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            fmv_pkg::CSR_DEPTH_INDEX:     depth_ff  <= csr_wdata[23:0];
            fmv_pkg::CSR_PHASE_INCREMENT: pinc_ff   <= csr_wdata;
            fmv_pkg::CSR_MEAN_OFFSET:     mean_ff   <= csr_wdata[23:0];
            fmv_pkg::CSR_LOOKAHEAD:       look_ff   <= csr_wdata[9:0];
            fmv_pkg::CSR_PAN:             pan_ff    <= csr_wdata[16:0];
            fmv_pkg::CSR_STEREO_OUT:      stereo_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // latched item
   logic [9:0]           addr_ff;
   logic signed [15:0]   tval_ff;
   logic signed [SB-1:0] samp_ff;
   logic [15:0]          gain_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         addr_ff <= req_tdata[9:0];
         tval_ff <= req_tdata[25:10];
         samp_ff <= req_tdata[26+SB-1:26];
         gain_ff <= req_tdata[42+SB-1:26+SB];
      end
   end

   // state
   logic [31:0]            phase_ff;
   logic signed [RO_W-1:0] ro_ff;
   logic [DAW-1:0]         wp_ff;
   logic [DAW-1:0]         clr_ptr_ff;
   logic                   rsp_valid_ff;

   logic signed [15:0]     t0_ff;
   logic signed [15:0]     t1_ff;
   logic signed [SB-1:0]   s0_ff;
   logic signed [SB-1:0]   s1_ff;
   logic signed [V_W-1:0]  acc_ff;
   logic signed [MA_W-1:0] a_ff;
   logic signed [P_W-1:0]  prod_ff;
   logic [DAW-1:0]         p0_ff;
   logic signed [SB-1:0]   left_ff;
   logic signed [SB-1:0]   right_ff;
   logic signed [SB-1:0]   rsp_left_ff;
   logic signed [SB-1:0]   rsp_right_ff;

   // table addressing
   logic [TAW-1:0] idx;
   logic [TAW-1:0] nxt;
   logic [15:0]    tbl_rdata;

   assign idx = tbl_mod(phase_ff[31:22]);
   assign nxt = (idx == TAW'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;

   fmv_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_table (
      .clock   (clock),
      .wr_en   (cmd.tbl_write),
      .wr_addr (tbl_mod(addr_ff)),
      .wr_data (tval_ff),
      .rd_addr (cmd.cap_t0 ? nxt : idx),
      .rd_data (tbl_rdata)
   );

   // ring addressing
   logic [DAW-1:0] p1;
   logic [SB-1:0]  ring_rdata;

   assign p1 = (p0_ff == DAW'(DELAY_DEPTH - 1)) ? '0 : p0_ff + 1'b1;

   fmv_ram #(.WIDTH(SB), .DEPTH(DELAY_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.clear_step | cmd.ring_write),
      .wr_addr (cmd.clear_step ? clr_ptr_ff : wp_ff),
      .wr_data (cmd.clear_step ? '0 : samp_ff),
      .rd_addr (cmd.ring_rd1 ? p1 : p0_ff),
      .rd_data (ring_rdata)
   );

   // shared multiplier
   logic signed [16:0]     diff;
   logic signed [16:0]     osc;
   logic [15:0]            w;
   logic [16:0]            wc;
   logic [16:0]            pl;
   logic signed [MA_W-1:0] ma;
   logic signed [MB_W-1:0] mb;

   assign diff = 17'(t1_ff) - 17'(t0_ff);
   assign osc  = 17'(t0_ff) + 17'(prod_ff >>> 22);
   assign w    = ro_ff[15:0];
   assign wc   = fmv_pkg::UNITY - 17'(w);
   assign pl   = (pan_ff > fmv_pkg::UNITY) ? fmv_pkg::UNITY : pan_ff;

   always_comb begin
      case (cmd.mul_sel)
         fmv_pkg::MUL_INTERP: begin
            ma = MA_W'(diff);
            mb = MB_W'(phase_ff[21:0]);
         end
         fmv_pkg::MUL_DEPTH: begin
            ma = MA_W'(osc);
            mb = MB_W'(depth_ff);
         end
         fmv_pkg::MUL_OLD: begin
            ma = MA_W'(s0_ff);
            mb = MB_W'(wc);
         end
         fmv_pkg::MUL_NEW: begin
            ma = MA_W'(s1_ff);
            mb = MB_W'(w);
         end
         fmv_pkg::MUL_GAIN: begin
            ma = MA_W'(acc_ff);
            mb = MB_W'(gain_ff);
         end
         fmv_pkg::MUL_PANL: begin
            ma = a_ff;
            mb = MB_W'(pl);
         end
         fmv_pkg::MUL_PANR: begin
            ma = a_ff;
            mb = MB_W'(fmv_pkg::UNITY - pl);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= P_W'(ma) * P_W'(mb);
   end

   // read offset update with saturation to the ring span
   logic signed [D_W-1:0]   delta;
   logic signed [SUM_W-1:0] sum;
   logic signed [RO_W-1:0]  la_s;
   logic signed [RO_W-1:0]  lo;
   logic signed [RO_W-1:0]  hi;
   logic signed [RO_W-1:0]  ro_in;

   assign delta = D_W'(prod_ff >>> 15) - D_W'(mean_ff);
   assign sum   = SUM_W'(ro_ff) + SUM_W'(delta);
   assign la_s  = RO_W'(look_ff);
   assign lo    = (la_s - RO_W'(DELAY_DEPTH - 1)) <<< 16;
   assign hi    = (la_s <<< 16) - RO_W'(1);

   always_comb begin
      ro_in = RO_W'(sum);
      if (sum > SUM_W'(hi)) ro_in = hi;
      if (sum < SUM_W'(lo)) ro_in = lo;
   end

   // older tap position
   logic signed [RO_W-1:0] age_full;
   logic [DAW-1:0]         age;
   logic [DAW:0]           pd;
   logic [DAW-1:0]         p0_in;

   assign age_full = la_s - (ro_ff >>> 16);
   assign age      = age_full[DAW-1:0];
   assign pd       = {1'b0, wp_ff} - {1'b0, age};
   assign p0_in    = pd[DAW] ? DAW'(pd + (DAW+1)'(DELAY_DEPTH)) : pd[DAW-1:0];

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.cap_t0)   t0_ff  <= tbl_rdata;
      if (cmd.cap_t1)   t1_ff  <= tbl_rdata;
      if (cmd.addr_calc) p0_ff <= p0_in;
      if (cmd.cap_s0)   s0_ff  <= ring_rdata;
      if (cmd.cap_s1)   s1_ff  <= ring_rdata;
      if (cmd.acc_load) acc_ff <= V_W'(prod_ff);
      if (cmd.acc_add)  acc_ff <= acc_ff + V_W'(prod_ff);
      if (cmd.cap_a)    a_ff   <= MA_W'(prod_ff >>> 14);
      if (cmd.cap_left)  left_ff  <= sat(P_W'(prod_ff >>> 32));
      if (cmd.cap_right) right_ff <= sat(P_W'(prod_ff >>> 32));
      if (cmd.out_load) begin
         if (stereo_ff) begin
            rsp_left_ff  <= left_ff;
            rsp_right_ff <= right_ff;
         end else begin
            rsp_left_ff  <= sat(P_W'(a_ff >>> 16));
            rsp_right_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         ro_ff        <= '0;
         wp_ff        <= '0;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.phase_adv)  phase_ff <= phase_ff + pinc_ff;
         if (cmd.offset_upd) ro_ff    <= ro_in;
         if (cmd.clear_step && clr_ptr_ff != DAW'(DELAY_DEPTH - 1)) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            wp_ff <= (wp_ff == DAW'(DELAY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_last = (clr_ptr_ff == DAW'(DELAY_DEPTH - 1));
   assign status.stereo     = stereo_ff;
   assign status.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({rsp_right_ff, rsp_left_ff});

endmodule

>>> hdl/fm_fractional_delay_vibrato_top.sv
`timescale 1ns / 1ps
// Vibrato by a moving fractional read tap in a delay ring.
// req_* channel: req_tuser = 0 writes one wavetable word (table_address,
// table_value); req_tuser = 1 processes one audio sample (sample_in, gain).
// Load transfers give no result; each sample transfer gives one rsp_*
// transfer carrying left_out and right_out.
// csr_*: a write lands at the clock edge where csr_we is high; write only
// while the block is idle.
// A load item writes its table word and returns to idle. A sample item
// steps through the pan states only in stereo mode; its result is loaded
// as the controller returns to idle, so rsp_tvalid and req_tready rise together.
// The whole sample path runs through one shared multiplier and table and
// ring memories with one read port each, stepped by the controller, so one
// item is in flight at a time.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and only its final step waits while rsp_tready stays low.
// Reset: synchronous. Afterwards the ring is cleared one entry per cycle
// with req_tready low; csr writes are taken as ever.
// The wavetable holds no defined content until written.

module fm_fractional_delay_vibrato_top #(
   parameter int DELAY_DEPTH = 1024,
   parameter int TABLE_SIZE  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // table_address, table_value, sample_in, gain
   input  logic [((42 + SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   // operation
   input  logic                                       req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // left_out, right_out
   output logic [((2 * SAMPLE_BITS + 7) / 8) * 8-1:0]  rsp_tdata,
   input  logic                                       csr_we,
   input  logic [fmv_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [fmv_pkg::CSR_DATA_W-1:0]             csr_wdata
);

   fmv_pkg::fmv_cmd_type    cmd;
   fmv_pkg::fmv_status_type status;

   fmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   fmv_datapath #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .TABLE_SIZE  (TABLE_SIZE),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
